// ===== rtl/core/psg_pkg.sv =====
// shared types, register codes and level table for the sound generator
`default_nettype none
package psg_pkg;

  localparam int unsigned LVL_W       = 14;
  localparam int unsigned MIX_W       = 16;
  localparam int unsigned OUT_TDATA_W = 64;

  localparam logic [1:0] REQ_SELECT = 2'd0;
  localparam logic [1:0] REQ_WRITE  = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;

  localparam logic [3:0] REG_TONE_BASE = 4'd0;
  localparam logic [3:0] REG_NOISE_PER = 4'd6;
  localparam logic [3:0] REG_MIXER     = 4'd7;
  localparam logic [3:0] REG_CTL_BASE  = 4'd8;
  localparam logic [3:0] REG_ENV_LO    = 4'd11;
  localparam logic [3:0] REG_ENV_HI    = 4'd12;
  localparam logic [3:0] REG_ENV_SHAPE = 4'd13;

  localparam logic [17:0] NOISE_TAPS = 18'h24000;
  localparam logic [4:0]  ENV_ALL    = 5'h1F;

  typedef struct packed {
    logic       wr_en;
    logic [3:0] idx;
    logic [7:0] data;
    logic       tick;
  } psg_bus_t;

  function automatic logic [15:0] tone_full(input logic [11:0] p);
    tone_full = {((p == 12'd0) ? 12'd1 : p), 4'b0000};
  endfunction

  function automatic logic [LVL_W-1:0] lvl_lookup(input logic [4:0] idx);
    case (idx)
      5'd0:  lvl_lookup = 14'd0;
      5'd1:  lvl_lookup = 14'd89;
      5'd2:  lvl_lookup = 14'd106;
      5'd3:  lvl_lookup = 14'd127;
      5'd4:  lvl_lookup = 14'd152;
      5'd5:  lvl_lookup = 14'd181;
      5'd6:  lvl_lookup = 14'd216;
      5'd7:  lvl_lookup = 14'd257;
      5'd8:  lvl_lookup = 14'd306;
      5'd9:  lvl_lookup = 14'd364;
      5'd10: lvl_lookup = 14'd433;
      5'd11: lvl_lookup = 14'd515;
      5'd12: lvl_lookup = 14'd613;
      5'd13: lvl_lookup = 14'd729;
      5'd14: lvl_lookup = 14'd867;
      5'd15: lvl_lookup = 14'd1031;
      5'd16: lvl_lookup = 14'd1226;
      5'd17: lvl_lookup = 14'd1458;
      5'd18: lvl_lookup = 14'd1733;
      5'd19: lvl_lookup = 14'd2060;
      5'd20: lvl_lookup = 14'd2449;
      5'd21: lvl_lookup = 14'd2911;
      5'd22: lvl_lookup = 14'd3460;
      5'd23: lvl_lookup = 14'd4113;
      5'd24: lvl_lookup = 14'd4889;
      5'd25: lvl_lookup = 14'd5811;
      5'd26: lvl_lookup = 14'd6907;
      5'd27: lvl_lookup = 14'd8209;
      5'd28: lvl_lookup = 14'd9757;
      5'd29: lvl_lookup = 14'd11597;
      5'd30: lvl_lookup = 14'd13784;
      default: lvl_lookup = 14'd16383;
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/three_tone_psg_with_noise_envelope.sv =====
// top level: register select and write decode, tone/noise/envelope units, mixer
// a tick transaction shows its levels on out_tdata in the cycle after acceptance
// throughput: one transaction per cycle while the output is not stalled; non-tick transactions yield no output
// the output register accepts a new transaction while the held result is taken
// reset (rst_n low, synchronous) clears all counters, lfsr to one, output invalid
// ticks give all-zero levels and leave counters alone until the first data write
`default_nettype none
module three_tone_psg_with_noise_envelope
  import psg_pkg::*;
#(
  parameter int unsigned TONE_CHANNELS = 3
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [7:0]             in_tdata,   // data
  input  wire logic [1:0]             in_tuser,   // req_type
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata   // channel_a_level, channel_b_level,
                                                  // channel_c_level, mixed_level, zero pad
);

  logic                   in_acc;
  logic [3:0]             sel_r, sel_nxt;
  logic                   active_r, active_nxt;
  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  psg_bus_t               bus;
  logic                   noise_phase;
  logic [4:0]             env_idx;
  logic [LVL_W-1:0]       env_level;
  logic                   ch_phase [TONE_CHANNELS];
  logic                   ch_ndis  [TONE_CHANNELS];
  logic [4:0]             ch_ctl   [TONE_CHANNELS];
  logic [LVL_W-1:0]       ch_amp   [TONE_CHANNELS];
  logic [LVL_W-1:0]       ch_lvl   [TONE_CHANNELS];
  logic [MIX_W-1:0]       mixed;

  assign in_tready = out_tready || !out_valid_r;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    bus.wr_en = in_acc && (in_tuser == REQ_WRITE);
    bus.idx   = sel_r;
    bus.data  = in_tdata;
    bus.tick  = in_acc && (in_tuser == REQ_TICK) && active_r;
  end

  always_comb begin
    sel_nxt    = sel_r;
    active_nxt = active_r;
    if (in_acc && in_tuser == REQ_SELECT) begin
      sel_nxt = in_tdata[3:0];
    end
    if (bus.wr_en) begin
      active_nxt = 1'b1;
    end
  end

  psg_noise u_noise (
    .clk         (clk),
    .rst_n       (rst_n),
    .bus         (bus),
    .phase_nxt_o (noise_phase)
  );

  psg_env u_env (
    .clk       (clk),
    .rst_n     (rst_n),
    .bus       (bus),
    .lvl_idx_o (env_idx)
  );

  assign env_level = lvl_lookup(env_idx);

  for (genvar i = 0; i < TONE_CHANNELS; i++) begin : g_tone
    psg_tone #(
      .IDX (i)
    ) u_tone (
      .clk         (clk),
      .rst_n       (rst_n),
      .bus         (bus),
      .phase_nxt_o (ch_phase[i]),
      .noise_dis_o (ch_ndis[i]),
      .ctl_o       (ch_ctl[i])
    );

    always_comb begin
      if (ch_ctl[i][4]) begin
        ch_amp[i] = env_level;
      end else if (ch_ctl[i][3:0] != 4'd0) begin
        ch_amp[i] = lvl_lookup({ch_ctl[i][3:0], 1'b1});
      end else begin
        ch_amp[i] = '0;
      end
      ch_lvl[i] = ((noise_phase || ch_ndis[i]) && ch_phase[i]) ? ch_amp[i] : '0;
    end
  end

  always_comb begin
    mixed        = '0;
    out_data_nxt = '0;
    for (int i = 0; i < TONE_CHANNELS; i++) begin
      mixed = mixed + MIX_W'(ch_lvl[i]);
      out_data_nxt[i*LVL_W +: LVL_W] = ch_lvl[i];
    end
    out_data_nxt[TONE_CHANNELS*LVL_W +: MIX_W] = mixed;
    if (!active_r) begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_r    <= sel_nxt;
      active_r <= active_nxt;
      if (in_tready) begin
        out_valid_r <= in_acc && (in_tuser == REQ_TICK);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_tuser == REQ_TICK) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_silent_before_write: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == REQ_TICK && !active_r) |=> (out_tdata == '0))
    else $error("tick before first write gave nonzero levels");

  a_mix_is_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[3*LVL_W +: MIX_W] ==
      MIX_W'(out_tdata[0 +: LVL_W]) + MIX_W'(out_tdata[LVL_W +: LVL_W])
      + MIX_W'(out_tdata[2*LVL_W +: LVL_W])))
    else $error("mixed level differs from channel sum");

  a_write_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser == REQ_WRITE) |=> active_r)
    else $error("write did not enable sound");

  a_no_result_non_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tuser != REQ_TICK && out_tready) |=> !out_tvalid)
    else $error("non-tick transaction produced a result");

endmodule
`default_nettype wire

// ===== rtl/core/psg_tone.sv =====
// one square tone channel with its period, mixer enables and channel control
`default_nettype none
module psg_tone
  import psg_pkg::*;
#(
  parameter int unsigned IDX = 0
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire psg_bus_t   bus,
  output logic            phase_nxt_o,
  output logic            noise_dis_o,
  output logic [4:0]      ctl_o
);

  localparam logic [3:0] REG_LO  = 4'(REG_TONE_BASE + 2 * IDX);
  localparam logic [3:0] REG_HI  = 4'(REG_TONE_BASE + 2 * IDX + 1);
  localparam logic [3:0] REG_CTL = 4'(REG_CTL_BASE + IDX);

  logic [11:0]        period_r, period_nxt;
  logic [15:0]        cnt_r, cnt_nxt;
  logic               phase_r, phase_nxt;
  logic               tdis_r, tdis_nxt;
  logic               ndis_r, ndis_nxt;
  logic [4:0]         ctl_r, ctl_nxt;
  logic [11:0]        new_per;
  logic signed [17:0] adj_sum;

  always_comb begin
    period_nxt = period_r;
    cnt_nxt    = cnt_r;
    phase_nxt  = phase_r;
    tdis_nxt   = tdis_r;
    ndis_nxt   = ndis_r;
    ctl_nxt    = ctl_r;
    new_per    = (bus.idx == REG_LO) ? {period_r[11:8], bus.data}
                                     : {bus.data[3:0], period_r[7:0]};
    adj_sum    = $signed({2'b00, cnt_r}) + $signed({2'b00, tone_full(new_per)})
               - $signed({2'b00, tone_full(period_r)});
    if (bus.wr_en) begin
      if (bus.idx == REG_LO || bus.idx == REG_HI) begin
        period_nxt = new_per;
        cnt_nxt    = adj_sum[17] ? 16'd0 : adj_sum[15:0];
      end
      if (bus.idx == REG_MIXER) begin
        tdis_nxt = bus.data[IDX];
        ndis_nxt = bus.data[IDX+3];
        if (bus.data[IDX]) begin
          phase_nxt = 1'b1;
        end
      end
      if (bus.idx == REG_CTL) begin
        ctl_nxt = bus.data[4:0];
      end
    end
    if (bus.tick) begin
      if (cnt_r != 16'd0) begin
        cnt_nxt = cnt_r - 16'd1;
      end else begin
        cnt_nxt = tone_full(period_r) - 16'd1;
        if (!tdis_r) begin
          phase_nxt = ~phase_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      cnt_r    <= '0;
      phase_r  <= 1'b0;
      tdis_r   <= 1'b0;
      ndis_r   <= 1'b0;
      ctl_r    <= '0;
    end else begin
      period_r <= period_nxt;
      cnt_r    <= cnt_nxt;
      phase_r  <= phase_nxt;
      tdis_r   <= tdis_nxt;
      ndis_r   <= ndis_nxt;
      ctl_r    <= ctl_nxt;
    end
  end

  assign phase_nxt_o = phase_nxt;
  assign noise_dis_o = ndis_r;
  assign ctl_o       = ctl_r;

endmodule
`default_nettype wire

// ===== rtl/core/psg_noise.sv =====
// noise source: 17-bit lfsr stepped by a 5-bit period counter
`default_nettype none
module psg_noise
  import psg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire psg_bus_t bus,
  output logic          phase_nxt_o
);

  logic [4:0]         period_r, period_nxt;
  logic [8:0]         cnt_r, cnt_nxt;
  logic [16:0]        shift_r, shift_nxt;
  logic               phase_r, phase_nxt;
  logic [8:0]         old_full, new_full;
  logic signed [10:0] adj_sum;
  logic [16:0]        fb;

  always_comb begin
    period_nxt = period_r;
    cnt_nxt    = cnt_r;
    shift_nxt  = shift_r;
    phase_nxt  = phase_r;
    old_full   = {((period_r == 5'd0) ? 5'd1 : period_r), 4'b0000};
    new_full   = {((bus.data[4:0] == 5'd0) ? 5'd1 : bus.data[4:0]), 4'b0000};
    adj_sum    = $signed({2'b00, cnt_r}) + $signed({2'b00, new_full})
               - $signed({2'b00, old_full});
    // taps after the shift, so the top tap lands in bit 16
    fb         = shift_r[0] ? 17'(NOISE_TAPS >> 1) : 17'd0;
    if (bus.wr_en && bus.idx == REG_NOISE_PER) begin
      period_nxt = bus.data[4:0];
      cnt_nxt    = adj_sum[10] ? 9'd0 : adj_sum[8:0];
    end
    if (bus.tick) begin
      if (cnt_r != 9'd0) begin
        cnt_nxt = cnt_r - 9'd1;
      end else begin
        cnt_nxt   = old_full - 9'd1;
        phase_nxt = phase_r ^ shift_r[0] ^ shift_r[1];
        shift_nxt = {1'b0, shift_r[16:1]} ^ fb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      cnt_r    <= '0;
      shift_r  <= 17'd1;
      phase_r  <= 1'b0;
    end else begin
      period_r <= period_nxt;
      cnt_r    <= cnt_nxt;
      shift_r  <= shift_nxt;
      phase_r  <= phase_nxt;
    end
  end

  assign phase_nxt_o = phase_nxt;

endmodule
`default_nettype wire

// ===== rtl/core/psg_env.sv =====
// envelope generator: period counter, 32-step ramp, attack, alternate and hold
`default_nettype none
module psg_env
  import psg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire psg_bus_t bus,
  output logic [4:0]    lvl_idx_o
);

  logic [15:0]        period_r, period_nxt;
  logic [19:0]        cnt_r, cnt_nxt;
  logic [4:0]         step_r, step_nxt;
  logic [4:0]         inv_r, inv_nxt;
  logic               hold_r, hold_nxt;
  logic               alt_r, alt_nxt;
  logic               holding_r, holding_nxt;
  logic [15:0]        new_per;
  logic [19:0]        old_full, new_full;
  logic signed [21:0] adj_sum;

  always_comb begin
    period_nxt  = period_r;
    cnt_nxt     = cnt_r;
    step_nxt    = step_r;
    inv_nxt     = inv_r;
    hold_nxt    = hold_r;
    alt_nxt     = alt_r;
    holding_nxt = holding_r;
    new_per     = (bus.idx == REG_ENV_LO) ? {period_r[15:8], bus.data}
                                          : {bus.data, period_r[7:0]};
    old_full    = (period_r == 16'd0) ? 20'd8 : {period_r, 4'b0000};
    new_full    = (new_per == 16'd0) ? 20'd8 : {new_per, 4'b0000};
    adj_sum     = $signed({2'b00, cnt_r}) + $signed({2'b00, new_full})
                - $signed({2'b00, old_full});
    if (bus.wr_en) begin
      if (bus.idx == REG_ENV_LO || bus.idx == REG_ENV_HI) begin
        period_nxt = new_per;
        cnt_nxt    = adj_sum[21] ? 20'd0 : adj_sum[19:0];
      end
      if (bus.idx == REG_ENV_SHAPE) begin
        inv_nxt     = bus.data[2] ? ENV_ALL : 5'd0;
        holding_nxt = 1'b0;
        if (bus.data[3]) begin
          hold_nxt = bus.data[0];
          alt_nxt  = bus.data[1];
        end else begin
          hold_nxt = 1'b1;
          alt_nxt  = bus.data[2];
        end
        cnt_nxt  = old_full;
        step_nxt = ENV_ALL;
      end
    end
    if (bus.tick && !holding_r) begin
      if (cnt_r != 20'd0) begin
        cnt_nxt = cnt_r - 20'd1;
      end else begin
        cnt_nxt = old_full - 20'd1;
        if (step_r != 5'd0) begin
          step_nxt = step_r - 5'd1;
        end else begin
          if (alt_r) begin
            inv_nxt = inv_r ^ ENV_ALL;
          end
          if (hold_r) begin
            holding_nxt = 1'b1;
            step_nxt    = 5'd0;
          end else begin
            step_nxt = ENV_ALL;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r  <= '0;
      cnt_r     <= '0;
      step_r    <= '0;
      inv_r     <= '0;
      hold_r    <= 1'b0;
      alt_r     <= 1'b0;
      holding_r <= 1'b0;
    end else begin
      period_r  <= period_nxt;
      cnt_r     <= cnt_nxt;
      step_r    <= step_nxt;
      inv_r     <= inv_nxt;
      hold_r    <= hold_nxt;
      alt_r     <= alt_nxt;
      holding_r <= holding_nxt;
    end
  end

  assign lvl_idx_o = step_nxt ^ inv_nxt;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the three-tone sound generator with noise and envelope
module tb_top;
  import psg_pkg::*;

  localparam logic [1:0] REQ_UNUSED     = 2'd3;
  localparam logic [3:0] REG_UNUSED_LO  = 4'd14;
  localparam logic [3:0] REG_UNUSED_HI  = 4'd15;
  localparam int unsigned RX_LONG_HOLD  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  localparam logic [LVL_W-1:0] DAC_LEVELS [32] = '{
    14'd0, 14'd89, 14'd106, 14'd127, 14'd152, 14'd181, 14'd216, 14'd257,
    14'd306, 14'd364, 14'd433, 14'd515, 14'd613, 14'd729, 14'd867, 14'd1031,
    14'd1226, 14'd1458, 14'd1733, 14'd2060, 14'd2449, 14'd2911, 14'd3460, 14'd4113,
    14'd4889, 14'd5811, 14'd6907, 14'd8209, 14'd9757, 14'd11597, 14'd13784, 14'd16383
  };

  typedef struct packed {
    logic [MIX_W-1:0] mix;
    logic [LVL_W-1:0] ch_c;
    logic [LVL_W-1:0] ch_b;
    logic [LVL_W-1:0] ch_a;
  } levels_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;   // data
  logic [1:0]             in_tuser;   // req_type
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // channel_a_level, channel_b_level,
                                      // channel_c_level, mixed_level, zero pad

  three_tone_psg_with_noise_envelope dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // predicted generator state
  logic [3:0]  sel_reg;
  logic        sound_on;
  logic [11:0] tone_per [3];
  logic [15:0] tone_cnt [3];
  logic        tone_ph  [3];
  logic        tone_off [3];
  logic        noise_off [3];
  logic [4:0]  chan_ctl [3];
  logic [4:0]  noise_per;
  logic [8:0]  noise_cnt;
  logic [16:0] lfsr;
  logic        noise_ph;
  logic [15:0] env_per;
  logic [19:0] env_cnt;
  logic [4:0]  env_step;
  logic [4:0]  env_inv;
  logic        env_hold;
  logic        env_alt;
  logic        env_holding;

  levels_t     levels_due [$];
  levels_t     got_levels;
  levels_t     want_levels;
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          quiet_cycles = 0;
  bit          idle_en = 1'b0;
  logic        rx_long_req;
  int unsigned rx_long_left;
  int unsigned rx_gap_left;

  task automatic clear_prediction();
    sel_reg = '0;
    sound_on = 1'b0;
    for (int ch = 0; ch < 3; ch++) begin
      tone_per[ch] = '0;
      tone_cnt[ch] = '0;
      tone_ph[ch] = 1'b0;
      tone_off[ch] = 1'b0;
      noise_off[ch] = 1'b0;
      chan_ctl[ch] = '0;
    end
    noise_per = '0;
    noise_cnt = '0;
    lfsr = 17'd1;
    noise_ph = 1'b0;
    env_per = '0;
    env_cnt = '0;
    env_step = '0;
    env_inv = '0;
    env_hold = 1'b0;
    env_alt = 1'b0;
    env_holding = 1'b0;
  endtask

  function automatic int unsigned tone_span(input logic [11:0] p);
    return ((p == 12'd0) ? 1 : int'(p)) * 16;
  endfunction

  function automatic int unsigned env_span(input logic [15:0] p);
    return (p == 16'd0) ? 8 : int'(p) * 16;
  endfunction

  function automatic int unsigned rebase_count(input int unsigned count,
                                               input int unsigned old_span,
                                               input int unsigned new_span);
    int t;
    t = int'(count) + int'(new_span) - int'(old_span);
    return (t < 0) ? 0 : t;
  endfunction

  task automatic apply_write(input logic [3:0] idx, input logic [7:0] d);
    int unsigned old_span;
    int ch;
    if (idx <= REG_TONE_BASE + 4'd5) begin
      ch = idx >> 1;
      old_span = tone_span(tone_per[ch]);
      if (idx[0]) tone_per[ch][11:8] = d[3:0];
      else tone_per[ch][7:0] = d;
      tone_cnt[ch] = 16'(rebase_count(tone_cnt[ch], old_span, tone_span(tone_per[ch])));
    end else begin
      case (idx)
        REG_NOISE_PER: begin
          old_span = tone_span({7'd0, noise_per});
          noise_per = d[4:0];
          noise_cnt = 9'(rebase_count(noise_cnt, old_span, tone_span({7'd0, noise_per})));
        end
        REG_MIXER: begin
          for (ch = 0; ch < 3; ch++) begin
            tone_off[ch] = d[ch];
            noise_off[ch] = d[ch + 3];
            if (tone_off[ch]) tone_ph[ch] = 1'b1;
          end
        end
        REG_CTL_BASE, REG_CTL_BASE + 4'd1, REG_CTL_BASE + 4'd2: begin
          chan_ctl[idx - REG_CTL_BASE] = d[4:0];
        end
        REG_ENV_LO, REG_ENV_HI: begin
          old_span = env_span(env_per);
          if (idx == REG_ENV_LO) env_per[7:0] = d;
          else env_per[15:8] = d;
          env_cnt = 20'(rebase_count(env_cnt, old_span, env_span(env_per)));
        end
        REG_ENV_SHAPE: begin
          env_inv = d[2] ? ENV_ALL : 5'd0;
          if (d[3]) begin
            env_hold = d[0];
            env_alt = d[1];
          end else begin
            env_hold = 1'b1;
            env_alt = d[2];
          end
          env_holding = 1'b0;
          env_cnt = 20'(env_span(env_per));
          env_step = ENV_ALL;
        end
        default: ;
      endcase
    end
  endtask

  task automatic step_envelope();
    if (env_holding) return;
    if (env_cnt != 0) begin
      env_cnt = env_cnt - 1'b1;
      return;
    end
    env_cnt = 20'(env_span(env_per) - 1);
    if (env_step != 0) begin
      env_step = env_step - 1'b1;
      return;
    end
    if (env_alt) env_inv = env_inv ^ ENV_ALL;
    if (env_hold) begin
      env_holding = 1'b1;
      env_step = 5'd0;
    end else begin
      env_step = ENV_ALL;
    end
  endtask

  task automatic step_noise();
    if (noise_cnt != 0) begin
      noise_cnt = noise_cnt - 1'b1;
      return;
    end
    noise_cnt = 9'(tone_span({7'd0, noise_per}) - 1);
    if (lfsr[0] ^ lfsr[1]) noise_ph = ~noise_ph;
    if (lfsr[0]) lfsr = 17'(({1'b0, lfsr} ^ NOISE_TAPS) >> 1);
    else lfsr = lfsr >> 1;
  endtask

  task automatic predict_levels(input logic [1:0] req, input logic [7:0] d);
    logic [LVL_W-1:0] env_lvl;
    logic [LVL_W-1:0] amp;
    logic [LVL_W-1:0] lvl [3];
    levels_t lv;
    lv = '0;
    case (req)
      REQ_SELECT: sel_reg = d[3:0];
      REQ_WRITE: begin
        sound_on = 1'b1;
        apply_write(sel_reg, d);
      end
      REQ_TICK: begin
        if (sound_on) begin
          step_envelope();
          step_noise();
          env_lvl = DAC_LEVELS[env_step ^ env_inv];
          for (int ch = 0; ch < 3; ch++) begin
            if (tone_cnt[ch] != 0) begin
              tone_cnt[ch] = tone_cnt[ch] - 1'b1;
            end else begin
              tone_cnt[ch] = 16'(tone_span(tone_per[ch]) - 1);
              if (!tone_off[ch]) tone_ph[ch] = ~tone_ph[ch];
            end
            if (chan_ctl[ch][4]) amp = env_lvl;
            else if (chan_ctl[ch][3:0] != 4'd0) amp = DAC_LEVELS[{chan_ctl[ch][3:0], 1'b1}];
            else amp = '0;
            lvl[ch] = ((noise_ph || noise_off[ch]) && tone_ph[ch]) ? amp : '0;
          end
          lv.ch_a = lvl[0];
          lv.ch_b = lvl[1];
          lv.ch_c = lvl[2];
          lv.mix = MIX_W'(lvl[0]) + MIX_W'(lvl[1]) + MIX_W'(lvl[2]);
        end
        levels_due.push_back(lv);
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch in %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_item(input logic [1:0] req, input logic [7:0] d);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_levels(req, d);
    items_sent++;
  endtask

  task automatic program_reg(input logic [3:0] idx, input logic [7:0] d);
    send_item(REQ_SELECT, {4'($urandom_range(0, 15)), idx});
    send_item(REQ_WRITE, d);
  endtask

  task automatic pause_sender();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (levels_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_reg_data(input logic [3:0] idx);
    case (idx)
      REG_TONE_BASE, REG_TONE_BASE + 4'd2, REG_TONE_BASE + 4'd4:
        return ($urandom_range(0, 1) != 0) ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
      REG_TONE_BASE + 4'd1, REG_TONE_BASE + 4'd3, REG_TONE_BASE + 4'd5:
        return ($urandom_range(0, 9) < 7) ? 8'd0 : 8'($urandom_range(0, 255));
      REG_ENV_LO:
        return ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
      REG_ENV_HI:
        return ($urandom_range(0, 9) < 8) ? 8'd0 : 8'($urandom_range(0, 255));
      default:
        return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic run_random_items(input int count);
    int stop_at;
    int roll;
    logic [3:0] idx;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        idx = 4'($urandom_range(0, 15));
        program_reg(idx, pick_reg_data(idx));
      end else if (roll < 85) begin
        repeat ($urandom_range(1, 24)) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
      end else if (roll < 90) begin
        send_item(REQ_SELECT, 8'($urandom_range(0, 255)));
      end else if (roll < 95) begin
        send_item(REQ_WRITE, 8'($urandom_range(0, 255)));
      end else begin
        send_item(REQ_UNUSED, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic test_quiet_start();
    send_item(REQ_TICK, 8'hFF);
    send_item(REQ_UNUSED, 8'h00);
    send_item(REQ_SELECT, {4'hF, REG_UNUSED_LO});
    send_item(REQ_TICK, 8'h00);
    // write to an unused register still wakes the generator
    send_item(REQ_WRITE, 8'hFF);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_UNUSED, 8'hFF);
  endtask

  task automatic test_register_map();
    program_reg(REG_CTL_BASE, 8'h0F);
    send_item(REQ_TICK, 8'h00);
    // tones off force phase high, noise off opens the gate
    program_reg(REG_MIXER, 8'h3F);
    send_item(REQ_TICK, 8'h00);
    program_reg(REG_CTL_BASE + 4'd1, 8'hFF);
    program_reg(REG_ENV_SHAPE, 8'h00);
    program_reg(REG_TONE_BASE + 4'd1, 8'hFF);
    // noise gate now decides
    program_reg(REG_MIXER, 8'h07);
    send_item(REQ_TICK, 8'h00);
    send_item(REQ_TICK, 8'hFF);
    program_reg(REG_UNUSED_HI, 8'h00);
  endtask

  task automatic test_random_program();
    idle_en = 1'b1;
    run_random_items(900);
  endtask

  task automatic test_output_backpressure();
    rx_long_req <= 1'b1;
    repeat (40) send_item(REQ_TICK, 8'($urandom_range(0, 255)));
    pause_sender();
    run_random_items(60);
  endtask

  task automatic test_quiet_tail();
    idle_en = 1'b0;
    run_random_items(250);
  endtask

  always @(posedge clk) begin
    if (rx_long_left != 0) begin
      out_tready <= 1'b0;
      rx_long_left <= rx_long_left - 1;
    end else if (rx_long_req) begin
      rx_long_req <= 1'b0;
      rx_long_left <= RX_LONG_HOLD;
      out_tready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      out_tready <= 1'b0;
      rx_gap_left <= rx_gap_left - 1;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      rx_gap_left <= $urandom_range(0, 15);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (levels_due.size() == 0) begin
        report_mismatch("unexpected transaction", 0, 0);
      end else begin
        want_levels = levels_due.pop_front();
        got_levels = levels_t'(out_tdata[$bits(levels_t)-1:0]);
        if (got_levels.ch_a !== want_levels.ch_a)
          report_mismatch("channel a level", got_levels.ch_a, want_levels.ch_a);
        if (got_levels.ch_b !== want_levels.ch_b)
          report_mismatch("channel b level", got_levels.ch_b, want_levels.ch_b);
        if (got_levels.ch_c !== want_levels.ch_c)
          report_mismatch("channel c level", got_levels.ch_c, want_levels.ch_c);
        if (got_levels.mix !== want_levels.mix)
          report_mismatch("mixed level", got_levels.mix, want_levels.mix);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    in_tuser     <= REQ_SELECT;
    out_tready   <= 1'b0;
    rx_long_req  <= 1'b0;
    rx_long_left <= 0;
    rx_gap_left  <= 0;
    clear_prediction();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_quiet_start();
    test_register_map();
    test_random_program();
    test_output_backpressure();
    test_quiet_tail();
    for (int n = 0; n < 3; n++) begin
      if (levels_due.size() != 0) pause_sender();
    end
    pause_sender();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && levels_due.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (levels_due.size() != 0)
        report_mismatch("results still outstanding", 0, levels_due.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
